/* design/sdspi_pkg.sv */
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD card SPI-mode command engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

   // Sequencing phases of one command run.
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_READY  = 4'd1,
      PH_PACKET = 4'd2,
      PH_STUFF  = 4'd3,
      PH_POLL   = 4'd4
   } phase_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_TX        = 3'd0,
      ST_DONE      = 3'd1,
      ST_READY_TO  = 3'd2,
      ST_RESP_TO   = 3'd3,
      ST_PREFIX_NO = 3'd4,
      ST_IGNORED   = 3'd5
   } status_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_READY_LIMIT = 1'b0,
      CSR_RESP_LIMIT  = 1'b1
   } csr_index_type;

   // Request and response data widths.
   localparam int unsigned ReqDataWidth  = 48;
   localparam int unsigned RspDataWidth  = 24;

   // Bytes and command numbers of the protocol.
   localparam logic [7:0] ByteIdle       = 8'hFF;
   localparam logic [7:0] CmdStart       = 8'h40;
   localparam logic [7:0] CrcCmd0        = 8'h95;
   localparam logic [7:0] CrcCmd8        = 8'h87;
   localparam logic [7:0] CrcCmd59       = 8'hAD;
   localparam logic [5:0] IdxGoIdle      = 6'd0;
   localparam logic [5:0] IdxIfCond      = 6'd8;
   localparam logic [5:0] IdxStopTran    = 6'd12;
   localparam logic [5:0] IdxAppCmd      = 6'd55;
   localparam logic [5:0] IdxCrcOnOff    = 6'd59;
   localparam logic [2:0] LastPacketPos  = 3'd5;
   localparam logic [7:0] ReadyLimitInit = 8'd100;
   localparam logic [7:0] RespLimitInit  = 8'd10;

   // Run state kept between items.
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  try_count;
      logic [2:0]  byte_position;
      logic [5:0]  held_index;
      logic [31:0] held_argument;
      logic        prefix_pending;
   } run_state_type;

   // One result item.
   typedef struct packed {
      status_type  status;
      logic [7:0]  tx_byte;
      logic        reselect;
      logic [7:0]  response;
   } result_type;

endpackage

`default_nettype wire

/* design/sd_spi_command_engine_core.sv */
// ----------------------------------------------------------------------------
// sd_spi_command_engine_core
// Host side of an SD card SPI-mode command exchange, one item per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes items: tuser is the mode (0 issue a command,
//   1 hand in the byte the card returned). A command item starts a run;
//   each following byte item is answered with the next byte to shift out
//   or with the final status of the run.
//   The rsp channel returns one item per request: tuser is the status,
//   tdata holds tx_byte, reselect and response.
//   The csr channel writes the ready and response retry limits; it is
//   always ready and should only be written while the engine is idle.
//   rsp valid is registered in the result register and rises in the cycle
//   after req acceptance. One item is accepted every cycle as long as the
//   result register is empty or being drained in the same cycle.
//   When rsp_tready is low with a result held, req_tready drops until it
//   is taken; nothing is lost or repeated.
//   Reset returns the run state to idle, empties the result register and
//   restores the retry limits to 100 and 10.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_command_engine_core
   import sdspi_pkg::*;
(
   input  var logic                    clock,
   input  var logic                    reset,
   // tdata: cmd_index[5:0], app_cmd[6], argument[38:7], rx_byte[46:39], zero pad
   input  var logic [ReqDataWidth-1:0] req_tdata,
   // tuser: mode[0]
   input  var logic                    req_tuser,
   input  var logic                    req_tvalid,
   output logic                        req_tready,
   // tdata: tx_byte[7:0], reselect[8], response[16:9], zero pad
   output logic [RspDataWidth-1:0]     rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]                  rsp_tuser,
   output logic                        rsp_tvalid,
   input  var logic                    rsp_tready,
   input  var logic                    csr_valid,
   output logic                        csr_ready,
   input  var logic                    csr_index,
   input  var logic [7:0]              csr_data
);

   run_state_type state_ff, state_in;
   logic [7:0]    ready_limit_ff, ready_limit_in;
   logic [7:0]    resp_limit_ff, resp_limit_in;
   result_type    step_result;
   result_type    rsp_data;
   logic          req_accept;

   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Configuration register writes.
   always_comb begin
      ready_limit_in = ready_limit_ff;
      resp_limit_in  = resp_limit_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_READY_LIMIT: ready_limit_in = csr_data;
            CSR_RESP_LIMIT:  resp_limit_in  = csr_data;
            default:         ready_limit_in = ready_limit_ff;
         endcase
      end
   end

   // Per-item state update.
   sdspi_step u_step (
      .cur_state   (state_ff),
      .mode        (req_tuser),
      .cmd_index   (req_tdata[5:0]),
      .app_cmd     (req_tdata[6]),
      .argument    (req_tdata[38:7]),
      .rx_byte     (req_tdata[46:39]),
      .ready_limit (ready_limit_ff),
      .resp_limit  (resp_limit_ff),
      .nxt_state   (state_in),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '{phase: PH_IDLE, try_count: 8'd0, byte_position: 3'd0,
                             held_index: 6'd0, held_argument: 32'd0,
                             prefix_pending: 1'b0};
         ready_limit_ff <= ReadyLimitInit;
         resp_limit_ff  <= RespLimitInit;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         ready_limit_ff <= ready_limit_in;
         resp_limit_ff  <= resp_limit_in;
      end
   end

   // Result register toward the rsp channel.
   sdspi_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .load_data (step_result),
      .can_load  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tuser = rsp_data.status;
   assign rsp_tdata = {7'd0, rsp_data.response, rsp_data.reselect, rsp_data.tx_byte};

endmodule

`default_nettype wire

/* design/sdspi_step.sv */
// ----------------------------------------------------------------------------
// sdspi_step
// Combinational next-state and result logic for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_step
   import sdspi_pkg::*;
(
   input  var run_state_type cur_state,
   input  var logic          mode,
   input  var logic [5:0]    cmd_index,
   input  var logic          app_cmd,
   input  var logic [31:0]   argument,
   input  var logic [7:0]    rx_byte,
   input  var logic [7:0]    ready_limit,
   input  var logic [7:0]    resp_limit,
   output run_state_type     nxt_state,
   output result_type        result
);

   logic [5:0]  active_idx;
   logic [31:0] active_arg;
   logic [7:0]  try_inc;
   logic [2:0]  pos_inc;

   // Command 55 carries a zero argument.
   assign active_idx = cur_state.prefix_pending ? IdxAppCmd : cur_state.held_index;
   assign active_arg = cur_state.prefix_pending ? 32'd0 : cur_state.held_argument;
   assign try_inc    = cur_state.try_count + 8'd1;
   assign pos_inc    = cur_state.byte_position + 3'd1;

   // Byte of the command frame at a given position.
   function automatic logic [7:0] packet_byte(input logic [2:0] pos,
                                              input logic [5:0] idx,
                                              input logic [31:0] arg);
      logic [7:0] b;
      unique case (pos)
         3'd0:    b = CmdStart | {2'b00, idx};
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         default: begin
            if (idx == IdxGoIdle)        b = CrcCmd0;
            else if (idx == IdxIfCond)   b = CrcCmd8;
            else if (idx == IdxCrcOnOff) b = CrcCmd59;
            else                         b = ByteIdle;
         end
      endcase
      return b;
   endfunction

   always_comb begin
      nxt_state = cur_state;
      result    = '{status: ST_IGNORED, tx_byte: 8'd0, reselect: 1'b0, response: 8'd0};

      if (!mode) begin
         // A new command starts a run only when idle.
         if (cur_state.phase == PH_IDLE) begin
            nxt_state.held_index     = cmd_index;
            nxt_state.held_argument  = argument;
            nxt_state.prefix_pending = app_cmd;
            nxt_state.phase          = PH_READY;
            nxt_state.try_count      = 8'd0;
            nxt_state.byte_position  = 3'd0;
            result = '{status: ST_TX, tx_byte: ByteIdle, reselect: 1'b1, response: 8'd0};
         end
      end else begin
         unique case (cur_state.phase)
            PH_READY: begin
               // Wait for the card to release the bus.
               if (rx_byte == ByteIdle) begin
                  nxt_state.phase         = PH_PACKET;
                  nxt_state.byte_position = 3'd0;
                  nxt_state.try_count     = 8'd0;
                  result.status  = ST_TX;
                  result.tx_byte = packet_byte(3'd0, active_idx, active_arg);
               end else if (try_inc >= ready_limit) begin
                  nxt_state.phase          = PH_IDLE;
                  nxt_state.try_count      = 8'd0;
                  nxt_state.byte_position  = 3'd0;
                  nxt_state.prefix_pending = 1'b0;
                  result.status   = ST_READY_TO;
                  result.response = ByteIdle;
               end else begin
                  nxt_state.try_count = try_inc;
                  result.status  = ST_TX;
                  result.tx_byte = ByteIdle;
               end
            end
            PH_PACKET: begin
               // Send the rest of the frame, then poll (stop transmission first sends a stuff byte).
               result.status = ST_TX;
               if (cur_state.byte_position < LastPacketPos) begin
                  nxt_state.byte_position = pos_inc;
                  result.tx_byte = packet_byte(pos_inc, active_idx, active_arg);
               end else begin
                  nxt_state.byte_position = 3'd0;
                  nxt_state.try_count     = 8'd0;
                  nxt_state.phase = (active_idx == IdxStopTran) ? PH_STUFF : PH_POLL;
                  result.tx_byte  = ByteIdle;
               end
            end
            PH_STUFF: begin
               // Stop transmission discards one stuff byte.
               nxt_state.phase     = PH_POLL;
               nxt_state.try_count = 8'd0;
               result.status  = ST_TX;
               result.tx_byte = ByteIdle;
            end
            PH_POLL: begin
               // A byte with bit 7 clear is the response.
               if (!rx_byte[7]) begin
                  if (cur_state.prefix_pending && (rx_byte <= 8'd1)) begin
                     nxt_state.prefix_pending = 1'b0;
                     nxt_state.phase          = PH_READY;
                     nxt_state.try_count      = 8'd0;
                     nxt_state.byte_position  = 3'd0;
                     result.status   = ST_TX;
                     result.tx_byte  = ByteIdle;
                     result.reselect = 1'b1;
                  end else begin
                     nxt_state.phase          = PH_IDLE;
                     nxt_state.try_count      = 8'd0;
                     nxt_state.byte_position  = 3'd0;
                     nxt_state.prefix_pending = 1'b0;
                     result.status   = cur_state.prefix_pending ? ST_PREFIX_NO : ST_DONE;
                     result.response = rx_byte;
                  end
               end else if (try_inc >= resp_limit) begin
                  nxt_state.phase          = PH_IDLE;
                  nxt_state.try_count      = 8'd0;
                  nxt_state.byte_position  = 3'd0;
                  nxt_state.prefix_pending = 1'b0;
                  result.status   = ST_RESP_TO;
                  result.response = rx_byte;
               end else begin
                  nxt_state.try_count = try_inc;
                  result.status  = ST_TX;
                  result.tx_byte = ByteIdle;
               end
            end
            default: begin
               // A received byte while idle is ignored.
               nxt_state.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/sdspi_rsp_reg.sv */
// ----------------------------------------------------------------------------
// sdspi_rsp_reg
// Result register that holds one item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_rsp_reg
   import sdspi_pkg::*;
(
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       load,
   input  var result_type load_data,
   output logic           can_load,
   output logic           out_valid,
   input  var logic       out_ready,
   output result_type     out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Space is free when empty or when the held item leaves this cycle.
   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
